// ===== sv/cascaded_biquad_filter_defines.svh =====
// ---------------------------------------------------------------------------
// Cascaded biquad filter assertion macros
// Shared forms for the concurrent checks of the filter block.
// ---------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_FILTER_DEFINES_SVH
`define CASCADED_BIQUAD_FILTER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define CBQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle
`define CBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cbq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad filter package
// Widths, register indexes, control word layout and the microprogram.
// ---------------------------------------------------------------------------
package cbq_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_SAMPLE_BITS  = 24;
   localparam int DEF_MAX_SECTIONS = 3;

   // Coefficient format Q4.22
   localparam int COEF_BITS = 26;
   localparam int COEF_FRAC = 22;

   // Configuration register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECTION_COUNT = 3'd5;

   localparam int                COUNT_BITS  = 2;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 2'd2;

   // Shared coefficient set
   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_set_type;

   // Microprogram steps
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_MUL_B0 = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_MUL_B1 = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_MUL_B2 = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_MUL_A1 = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_MUL_A2 = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_ACC_A2 = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_ROUND  = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_SHIFT  = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_END    = 4'd8;

   typedef enum logic [2:0] {
      COEF_SEL_B0,
      COEF_SEL_B1,
      COEF_SEL_B2,
      COEF_SEL_A1,
      COEF_SEL_A2
   } coef_sel_type;

   typedef enum logic {
      OPD_X,
      OPD_HIST
   } opd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_END
   } seq_op_type;

   // One control word of the microprogram
   typedef struct packed {
      logic         mul_en;    // load the product register
      coef_sel_type coef_sel;
      opd_sel_type  opd_sel;
      logic         row_off;   // 0: this section's input row, 1: its output row
      logic         col;       // 0: one sample back, 1: two samples back
      acc_op_type   acc_op;
      logic         round_en;  // round and saturate the accumulator
      logic         adv_en;    // pass the section output on as next input
      logic         shift_en;  // push the current input into the history row
      logic         emit;      // hand the final output to the result register
      seq_op_type   seq_op;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_NOP = '{
      mul_en:   1'b0,
      coef_sel: COEF_SEL_B0,
      opd_sel:  OPD_X,
      row_off:  1'b0,
      col:      1'b0,
      acc_op:   ACC_HOLD,
      round_en: 1'b0,
      adv_en:   1'b0,
      shift_en: 1'b0,
      emit:     1'b0,
      seq_op:   SEQ_NEXT
   };

   // Microcode ROM: eight steps per section, then one closing step
   function automatic ctrl_word_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type w;
      w = CTRL_NOP;
      case (step)
         STEP_MUL_B0: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_SEL_B0;
            w.opd_sel  = OPD_X;
         end
         STEP_MUL_B1: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_SEL_B1;
            w.opd_sel  = OPD_HIST;
            w.row_off  = 1'b0;
            w.col      = 1'b0;
            w.acc_op   = ACC_LOAD;
         end
         STEP_MUL_B2: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_SEL_B2;
            w.opd_sel  = OPD_HIST;
            w.row_off  = 1'b0;
            w.col      = 1'b1;
            w.acc_op   = ACC_ADD;
         end
         STEP_MUL_A1: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_SEL_A1;
            w.opd_sel  = OPD_HIST;
            w.row_off  = 1'b1;
            w.col      = 1'b0;
            w.acc_op   = ACC_ADD;
         end
         STEP_MUL_A2: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_SEL_A2;
            w.opd_sel  = OPD_HIST;
            w.row_off  = 1'b1;
            w.col      = 1'b1;
            w.acc_op   = ACC_SUB;
         end
         STEP_ACC_A2: begin
            w.acc_op = ACC_SUB;
         end
         STEP_ROUND: begin
            w.round_en = 1'b1;
         end
         STEP_SHIFT: begin
            w.shift_en = 1'b1;
            w.adv_en   = 1'b1;
            w.seq_op   = SEQ_LOOP;
         end
         STEP_END: begin
            w.shift_en = 1'b1;
            w.emit     = 1'b1;
            w.seq_op   = SEQ_END;
         end
         default: begin
            w = CTRL_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/cbq_sequencer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad microsequencer
// Steps through the microcode ROM once per section and issues control words.
// ---------------------------------------------------------------------------
module cbq_sequencer #(
   parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 hold,
   output logic                                 busy,
   output logic [$clog2(MAX_SECTIONS+1)-1:0]    sec,
   output cbq_pkg::ctrl_word_type               ctrl
);

   localparam int SEC_W = $clog2(MAX_SECTIONS + 1);
   localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(MAX_SECTIONS - 1);

   logic                              running_ff, running_in;
   logic [cbq_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [SEC_W-1:0]                  sec_ff, sec_in;
   cbq_pkg::ctrl_word_type            word;

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= cbq_pkg::STEP_MUL_B0;
         sec_ff     <= '0;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
         sec_ff     <= sec_in;
      end
   end

   // Fetch the control word and pick the next step
   always_comb begin
      word       = cbq_pkg::ucode_rom(step_ff);
      ctrl       = cbq_pkg::CTRL_NOP;
      running_in = running_ff;
      step_in    = step_ff;
      sec_in     = sec_ff;
      if (!running_ff) begin
         if (start) begin
            running_in = 1'b1;
            step_in    = cbq_pkg::STEP_MUL_B0;
            sec_in     = '0;
         end
      end else begin
         case (word.seq_op)
            cbq_pkg::SEQ_NEXT: begin
               ctrl    = word;
               step_in = step_ff + cbq_pkg::STEP_BITS'(1);
            end
            cbq_pkg::SEQ_LOOP: begin
               ctrl   = word;
               sec_in = sec_ff + SEC_W'(1);
               if (sec_ff == SEC_LAST) begin
                  step_in = cbq_pkg::STEP_END;
               end else begin
                  step_in = cbq_pkg::STEP_MUL_B0;
               end
            end
            cbq_pkg::SEQ_END: begin
               // wait here while the previous result is still unclaimed
               if (!hold) begin
                  ctrl       = word;
                  running_in = 1'b0;
               end
            end
            default: begin
               running_in = 1'b0;
            end
         endcase
      end
   end

   assign busy = running_ff;
   assign sec  = sec_ff;

endmodule

// ===== sv/cbq_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad datapath
// Shared multiplier, accumulator, rounding/saturation and history rows.
// ---------------------------------------------------------------------------
module cbq_datapath #(
   parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  logic signed [SAMPLE_BITS-1:0]           sample_in,
   input  cbq_pkg::coef_set_type                   coefs,
   input  logic [cbq_pkg::COUNT_BITS-1:0]          section_count,
   input  logic [$clog2(MAX_SECTIONS+1)-1:0]       sec,
   input  cbq_pkg::ctrl_word_type                  ctrl,
   output logic signed [SAMPLE_BITS-1:0]           sample_out
);

   localparam int SEC_W  = $clog2(MAX_SECTIONS + 1);
   localparam int CMP_W  = SEC_W + cbq_pkg::COUNT_BITS;
   localparam int PROD_W = cbq_pkg::COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int R_W    = ACC_W + 1 - cbq_pkg::COEF_FRAC;
   localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W + 1)'(2 ** (cbq_pkg::COEF_FRAC - 1));
   localparam logic signed [R_W-1:0] SAT_HI =
      {{(R_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [R_W-1:0] SAT_LO =
      {{(R_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

   // Row 0 holds the input history, row s+1 the output history of section s
   logic signed [SAMPLE_BITS-1:0] hist_ff [MAX_SECTIONS+1][2];

   logic signed [SAMPLE_BITS-1:0]     x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0]     y_ff, y_in;
   logic signed [SAMPLE_BITS-1:0]     ys_ff, ys_in;
   logic signed [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic signed [cbq_pkg::COEF_BITS-1:0] coef_mux;
   logic signed [SAMPLE_BITS-1:0]     opnd_mux;
   logic [SEC_W-1:0]                  rd_row;
   logic signed [ACC_W:0]             rnd_sum;
   logic signed [R_W-1:0]             rnd_q;
   logic                              sec_active;

   // Select multiplier operands
   always_comb begin
      rd_row = sec + SEC_W'(ctrl.row_off);
      case (ctrl.coef_sel)
         cbq_pkg::COEF_SEL_B0: coef_mux = coefs.b0;
         cbq_pkg::COEF_SEL_B1: coef_mux = coefs.b1;
         cbq_pkg::COEF_SEL_B2: coef_mux = coefs.b2;
         cbq_pkg::COEF_SEL_A1: coef_mux = coefs.a1;
         cbq_pkg::COEF_SEL_A2: coef_mux = coefs.a2;
         default:              coef_mux = coefs.b0;
      endcase
      if (ctrl.opd_sel == cbq_pkg::OPD_X) begin
         opnd_mux = x_ff;
      end else begin
         opnd_mux = hist_ff[rd_row][ctrl.col];
      end
      prod_in = coef_mux * opnd_mux;
   end

   // Accumulate the registered product
   always_comb begin
      case (ctrl.acc_op)
         cbq_pkg::ACC_LOAD: acc_in = ACC_W'(prod_ff);
         cbq_pkg::ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         cbq_pkg::ACC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         default:           acc_in = acc_ff;
      endcase
   end

   // Round half up to Q1.23, then saturate to the sample range
   always_comb begin
      rnd_sum = (ACC_W + 1)'(acc_ff) + RND_BIAS;
      rnd_q   = rnd_sum[ACC_W:cbq_pkg::COEF_FRAC];
      if (rnd_q > SAT_HI) begin
         ys_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (rnd_q < SAT_LO) begin
         ys_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         ys_in = rnd_q[SAMPLE_BITS-1:0];
      end
   end

   // A zero count still runs the first section
   assign sec_active = (sec == '0) || (CMP_W'(sec) < CMP_W'(section_count));

   // Advance the cascade: an idle section passes zero on
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (load) begin
         x_in = sample_in;
      end else if (ctrl.adv_en) begin
         if (sec_active) begin
            x_in = ys_ff;
            y_in = ys_ff;
         end else begin
            x_in = '0;
         end
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.round_en) begin
         ys_ff <= ys_in;
      end
   end

   // Shift history rows; all history starts at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r <= MAX_SECTIONS; r++) begin
            hist_ff[r][0] <= '0;
            hist_ff[r][1] <= '0;
         end
      end else if (ctrl.shift_en) begin
         hist_ff[sec][1] <= hist_ff[sec][0];
         hist_ff[sec][0] <= x_ff;
      end
   end

   assign sample_out = y_ff;

endmodule

// ===== sv/cascaded_biquad_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad filter
// One to MAX_SECTIONS Direct Form I biquads on a shared coefficient set.
// ---------------------------------------------------------------------------
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   req      | req_valid / req_stall  | req_sample_in  (Q1.23)
//   rsp      | rsp_valid / rsp_stall  | rsp_sample_out (Q1.23, saturated)
//   csr      | csr_valid / csr_ready  | csr_index, csr_wdata
//
// An item runs 8 * MAX_SECTIONS + 1 microprogram steps on one shared
// multiplier (25 steps for three sections); the next item can be taken in
// the cycle after the closing step, not before it.
// Synchronous reset clears coefficients and history and sets two sections.
// The closing step waits while an earlier result is stalled on rsp.
// ---------------------------------------------------------------------------
module cascaded_biquad_filter #(
   parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input samples
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   // filtered samples
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cbq_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [cbq_pkg::COEF_BITS-1:0]          csr_wdata
);

   localparam int SEC_W = $clog2(MAX_SECTIONS + 1);

   cbq_pkg::coef_set_type               coefs_ff, coefs_in;
   logic [cbq_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]       rsp_data_ff, rsp_data_in;
   logic                                busy;
   logic                                req_accept;
   logic                                rsp_hold;
   logic [SEC_W-1:0]                    sec;
   cbq_pkg::ctrl_word_type              ctrl;
   logic signed [SAMPLE_BITS-1:0]       filt_out;

   assign req_accept = req_valid && !busy;
   assign rsp_hold   = rsp_valid_ff && rsp_stall;

   // Decode register writes
   always_comb begin
      coefs_in = coefs_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index)
            cbq_pkg::CSR_COEF_B0:       coefs_in.b0 = csr_wdata;
            cbq_pkg::CSR_COEF_B1:       coefs_in.b1 = csr_wdata;
            cbq_pkg::CSR_COEF_B2:       coefs_in.b2 = csr_wdata;
            cbq_pkg::CSR_COEF_A1:       coefs_in.a1 = csr_wdata;
            cbq_pkg::CSR_COEF_A2:       coefs_in.a2 = csr_wdata;
            cbq_pkg::CSR_SECTION_COUNT: count_in    = csr_wdata[cbq_pkg::COUNT_BITS-1:0];
            default: begin
               // drop writes to unmapped indexes
               count_in = count_ff;
            end
         endcase
      end
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
         count_ff <= cbq_pkg::COUNT_RESET;
      end else begin
         coefs_ff <= coefs_in;
         count_ff <= count_in;
      end
   end

   // Load the result register; keep it while stalled
   always_comb begin
      rsp_valid_in = ctrl.emit || rsp_hold;
      rsp_data_in  = ctrl.emit ? filt_out : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   cbq_sequencer #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .hold  (rsp_hold),
      .busy  (busy),
      .sec   (sec),
      .ctrl  (ctrl)
   );

   cbq_datapath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (req_accept),
      .sample_in     (req_sample_in),
      .coefs         (coefs_ff),
      .section_count (count_ff),
      .sec           (sec),
      .ctrl          (ctrl),
      .sample_out    (filt_out)
   );

   assign req_stall      = busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign csr_ready      = 1'b1;

endmodule

// ===== sv/cbq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad port checker
// Watches the top-level ports for sequencing and result handshake slips.
// ---------------------------------------------------------------------------
`include "cascaded_biquad_filter_defines.svh"

module cbq_checker #(
   parameter int SAMPLE_BITS = cbq_pkg::DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   // An accepted item occupies the block in the next cycle
   `CBQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not blocked after an accepted item")

   // No result appears the cycle right after an item is taken
   `CBQ_ASSERT_NEXT(a_no_instant_result, clock, reset, req_valid && !req_stall, !$rose(rsp_valid), "result raised one cycle after accept")

   // A new result only comes out of work in progress
   `CBQ_ASSERT_SAME(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result raised while the block was idle")

   // A stalled result stays and does not change
   `CBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out), "stalled result dropped or changed")

endmodule

bind cascaded_biquad_filter cbq_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_cbq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

// ===== sim/cascaded_biquad_filter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad filter checker
// Watches the sample, result and register channels of the filter, keeps its
// own copy of the coefficients and the per-section history, predicts each
// filtered sample and compares it with the one the block hands out.
// ---------------------------------------------------------------------------
module cascaded_biquad_filter_checker #(
   parameter int SAMPLE_BITS  = cbq_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_SECTIONS = cbq_pkg::DEF_MAX_SECTIONS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cbq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cbq_pkg::COEF_BITS-1:0]      csr_wdata,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 checked_count,
   output int                                 saturation_count
);

   import cbq_pkg::*;

   localparam int     REPORT_LIMIT = 10;
   localparam longint SAMPLE_HI    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO    = -SAMPLE_HI - 1;
   localparam longint ROUND_HALF   = longint'(1) <<< (COEF_FRAC - 1);

   coef_set_type                  coefs;
   logic [COUNT_BITS-1:0]         sections_cfg;
   logic signed [SAMPLE_BITS-1:0] input_taps [2];
   logic signed [SAMPLE_BITS-1:0] output_taps [MAX_SECTIONS][2];
   logic signed [SAMPLE_BITS-1:0] expected_samples [$];
   int                            mismatches;
   int                            compared;
   int                            saturations;

   // Run one sample through the active sections and advance all history
   function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
      input logic signed [SAMPLE_BITS-1:0] sample
   );
      longint x, x1, x2, y1, y2, ys, y, acc;
      int     active;
      active = int'(sections_cfg);
      if (active == 0) active = 1;
      if (active > MAX_SECTIONS) active = MAX_SECTIONS;
      x  = longint'(sample);
      x1 = longint'(input_taps[0]);
      x2 = longint'(input_taps[1]);
      y  = 0;
      input_taps[1] = input_taps[0];
      input_taps[0] = sample;
      for (int s = 0; s < MAX_SECTIONS; s++) begin
         y1 = longint'(output_taps[s][0]);
         y2 = longint'(output_taps[s][1]);
         ys = 0;
         if (s < active) begin
            acc = longint'(coefs.b0) * x + longint'(coefs.b1) * x1
                + longint'(coefs.b2) * x2 - longint'(coefs.a1) * y1
                - longint'(coefs.a2) * y2;
            // round half up, then clamp to the sample range
            ys = (acc + ROUND_HALF) >>> COEF_FRAC;
            if (ys > SAMPLE_HI) begin
               ys = SAMPLE_HI;
               saturations++;
            end else if (ys < SAMPLE_LO) begin
               ys = SAMPLE_LO;
               saturations++;
            end
            y = ys;
         end
         output_taps[s][1] = SAMPLE_BITS'(y1);
         output_taps[s][0] = SAMPLE_BITS'(ys);
         // this section's samples feed the next one
         x  = ys;
         x1 = y1;
         x2 = y2;
      end
      return y[SAMPLE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (reset) begin
         coefs        = '0;
         sections_cfg = COUNT_RESET;
         input_taps   = '{default: '0};
         for (int s = 0; s < MAX_SECTIONS; s++) output_taps[s] = '{default: '0};
         expected_samples.delete();
         mismatches   = 0;
         compared     = 0;
         saturations  = 0;
      end else begin
         // track register writes; unknown indexes change nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_B0:       coefs.b0     = csr_wdata;
               CSR_COEF_B1:       coefs.b1     = csr_wdata;
               CSR_COEF_B2:       coefs.b2     = csr_wdata;
               CSR_COEF_A1:       coefs.a1     = csr_wdata;
               CSR_COEF_A2:       coefs.a2     = csr_wdata;
               CSR_SECTION_COUNT: sections_cfg = csr_wdata[COUNT_BITS-1:0];
               default: ;
            endcase
         end
         // predict each accepted item
         if (req_valid && !req_stall) expected_samples.push_back(filter_sample(req_sample_in));
         // compare each delivered item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected output sample %0d", rsp_sample_out);
            end else begin
               want = expected_samples.pop_front();
               compared++;
               if (rsp_sample_out !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("sample %0d: expected %0d, got %0d", compared, want,
                              rsp_sample_out);
               end
            end
         end
      end
      error_count      <= mismatches;
      pending_count    <= expected_samples.size();
      checked_count    <= compared;
      saturation_count <= saturations;
   end

endmodule

// ===== sim/cascaded_biquad_filter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad filter testbench
// Streams samples through the filter under many coefficient and section
// settings, with random input gaps and output stalls and one long
// output hold-off; the checker predicts every output and counts mismatches.
// ---------------------------------------------------------------------------
module cascaded_biquad_filter_tb;

   import cbq_pkg::*;

   localparam int SAMPLE_BITS      = DEF_SAMPLE_BITS;
   localparam int MAX_SECTIONS     = DEF_MAX_SECTIONS;
   localparam int RESET_CYCLES     = 10;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int LIMIT_CYCLES     = 2000000;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_ITEMS      = 120;
   localparam int PRESSURE_PHASE   = 5;

   // indexes outside the register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_7 = 3'd7;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] HALF_LSB   = SAMPLE_BITS'(1 << (COEF_FRAC - 1));
   localparam logic [COEF_BITS-1:0] COEF_MAX       = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic [COEF_BITS-1:0] COEF_MIN       = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic [COEF_BITS-1:0] COEF_ONE       = COEF_BITS'(1 << COEF_FRAC);
   localparam logic [COEF_BITS-1:0] COEF_MINUS_ONE = COEF_BITS'(-(1 << COEF_FRAC));
   localparam logic [COEF_BITS-1:0] COEF_LSB       = COEF_BITS'(1);

   typedef enum int {
      STYLE_FILTER,
      STYLE_WIDE,
      STYLE_EXTREME
   } setting_style_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_valid     = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index     = '0;
   logic [COEF_BITS-1:0]          csr_wdata     = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int saturation_count;
   int samples_sent     = 0;
   int settings_applied = 0;
   int cycle_count      = 0;
   bit long_hold_go     = 1'b0;
   bit long_hold_done   = 1'b0;

   cascaded_biquad_filter #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_SECTIONS (MAX_SECTIONS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   cascaded_biquad_filter_checker #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_SECTIONS (MAX_SECTIONS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .saturation_count (saturation_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Output side: random stalls, free-running stretches and one long hold-off
   initial begin
      int mode;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_go && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 60)) @(posedge clock);
            end else if (mode < 8) begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
               @(posedge clock);
            end else if (mode == 8) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(2, 8)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 120)) @(posedge clock);
            end
         end
      end
   end

   // Idle cycles before the next item: mostly short, a few long
   function automatic int pick_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 5);
      if (r < 95) return $urandom_range(6, 30);
      return $urandom_range(40, 120);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic [31:0] r;
      int          v;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2: begin
            v = int'($urandom_range(0, 8192)) - 4096;
            return v[SAMPLE_BITS-1:0];
         end
         default: return r[SAMPLE_BITS-1:0];
      endcase
   endfunction

   // New coefficient in the given style; span bounds the filter-like values
   function automatic logic [COEF_BITS-1:0] pick_coef(input setting_style_type style,
                                                      input int span);
      logic [31:0] r;
      int          v;
      r = $urandom();
      case (style)
         STYLE_FILTER: begin
            v = int'($urandom_range(0, 2 * span)) - span;
            return v[COEF_BITS-1:0];
         end
         STYLE_WIDE: return r[COEF_BITS-1:0];
         default: begin
            case ($urandom_range(0, 4))
               0:       return COEF_MAX;
               1:       return COEF_MIN;
               2:       return '0;
               3:       return COEF_ONE;
               default: return COEF_MINUS_ONE;
            endcase
         end
      endcase
   endfunction

   // Offer one item after a gap and hold it until accepted
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Write one register; valid stays up for back-to-back writes
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [COEF_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Drop the input and wait until every predicted sample has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random setting: each register written with high probability
   task automatic apply_setting(input setting_style_type style);
      logic [31:0] r;
      r = $urandom();
      if ($urandom_range(0, 4) != 0) write_reg(CSR_COEF_B0, pick_coef(style, 1 << 22));
      if ($urandom_range(0, 4) != 0) write_reg(CSR_COEF_B1, pick_coef(style, 1 << 22));
      if ($urandom_range(0, 4) != 0) write_reg(CSR_COEF_B2, pick_coef(style, 1 << 22));
      if ($urandom_range(0, 4) != 0) write_reg(CSR_COEF_A1, pick_coef(style, 1 << 23));
      if ($urandom_range(0, 4) != 0) write_reg(CSR_COEF_A2, pick_coef(style, 1 << 21));
      if ($urandom_range(0, 4) != 0) write_reg(CSR_SECTION_COUNT, r[COEF_BITS-1:0]);
      if ($urandom_range(0, 3) == 0) begin
         r = $urandom();
         write_reg($urandom_range(0, 1) ? CSR_UNUSED_6 : CSR_UNUSED_7, r[COEF_BITS-1:0]);
      end
      end_writes();
   endtask

   initial begin
      setting_style_type style;
      bit                burst;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset setting: zero coefficients give silence
      send_sample(SAMPLE_MAX, pick_gap(1'b0));
      send_sample(SAMPLE_MIN, pick_gap(1'b0));

      // unit gain, zero section count behaves as one section
      wait_drained();
      write_reg(CSR_COEF_B0, COEF_ONE);
      write_reg(CSR_COEF_B1, '0);
      write_reg(CSR_COEF_B2, '0);
      write_reg(CSR_COEF_A1, '0);
      write_reg(CSR_COEF_A2, '0);
      write_reg(CSR_SECTION_COUNT, '0);
      end_writes();
      send_sample(SAMPLE_MAX, pick_gap(1'b0));
      send_sample(SAMPLE_MIN, pick_gap(1'b0));
      send_sample('0, pick_gap(1'b0));
      send_sample('1, pick_gap(1'b0));

      // extreme gains over three sections: saturate both ways
      wait_drained();
      write_reg(CSR_COEF_B0, COEF_MAX);
      write_reg(CSR_COEF_B1, COEF_MIN);
      write_reg(CSR_SECTION_COUNT, COEF_BITS'(3));
      end_writes();
      send_sample(SAMPLE_MAX, pick_gap(1'b0));
      send_sample(SAMPLE_MIN, pick_gap(1'b0));
      send_sample(SAMPLE_MAX, pick_gap(1'b0));
      send_sample(SAMPLE_BITS'(1), pick_gap(1'b0));

      // ignored indexes, extreme feedback, count with upper data bits set
      wait_drained();
      write_reg(CSR_UNUSED_6, COEF_MAX);
      write_reg(CSR_UNUSED_7, COEF_MIN);
      write_reg(CSR_COEF_B0, COEF_ONE >> 1);
      write_reg(CSR_COEF_B1, COEF_ONE >> 1);
      write_reg(CSR_COEF_B2, COEF_MAX);
      write_reg(CSR_COEF_A1, COEF_MIN);
      write_reg(CSR_COEF_A2, COEF_MAX);
      write_reg(CSR_SECTION_COUNT, {{(COEF_BITS-COUNT_BITS){1'b1}}, 2'b01});
      end_writes();
      send_sample(SAMPLE_MAX, pick_gap(1'b0));
      send_sample(SAMPLE_MIN, pick_gap(1'b0));
      send_sample('0, pick_gap(1'b0));
      send_sample('0, pick_gap(1'b0));
      send_sample(SAMPLE_BITS'(12345), pick_gap(1'b0));

      // rounding of exact halves toward plus infinity
      wait_drained();
      write_reg(CSR_COEF_B0, COEF_LSB);
      write_reg(CSR_COEF_B1, '0);
      write_reg(CSR_COEF_B2, '0);
      write_reg(CSR_COEF_A1, '0);
      write_reg(CSR_COEF_A2, '0);
      write_reg(CSR_SECTION_COUNT, COEF_BITS'(1));
      end_writes();
      send_sample(HALF_LSB, pick_gap(1'b0));
      send_sample(-HALF_LSB, pick_gap(1'b0));
      send_sample(SAMPLE_BITS'(3 * HALF_LSB), pick_gap(1'b0));
      send_sample(SAMPLE_BITS'(-3 * HALF_LSB), pick_gap(1'b0));

      // random settings, each followed by a random sample stream
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase % 4)
            0, 1:    style = STYLE_FILTER;
            2:       style = STYLE_WIDE;
            default: style = STYLE_EXTREME;
         endcase
         apply_setting(style);
         burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PRESSURE_PHASE && n == 20) long_hold_go = 1'b1;
            // keep offering items while the output is held off
            send_sample(pick_sample(),
                        (long_hold_go && !long_hold_done) ? 0 : pick_gap(burst));
         end
      end

      wait_drained();
      $display("Sent %0d samples under %0d register settings, section counts 0 to 3.",
               samples_sent, settings_applied);
      $display("Compared %0d outputs; %0d section results saturated.",
               checked_count, saturation_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cbq_pkg.sv
sv/cbq_sequencer.sv
sv/cbq_datapath.sv
sv/cascaded_biquad_filter.sv
sv/cbq_checker.sv
sim/cascaded_biquad_filter_checker.sv
sim/cascaded_biquad_filter_tb.sv
